// ===== hdl/two_list_lru_page_replacement_assert.svh =====
// ----------------------------------------------------------------------------
// two_list_lru_page_replacement_assert.svh
// assertion macros used by the checker file of the page replacement block
// ----------------------------------------------------------------------------
`ifndef TWO_LIST_LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define TWO_LIST_LRU_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication, off while reset is low
`define TLLRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tllru assertion failed");

// next-cycle implication, off while reset is low
`define TLLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tllru assertion failed");

`endif

// ===== hdl/tllru_pkg.sv =====
// ----------------------------------------------------------------------------
// tllru_pkg
// types and constants of the two-list lru page replacement block
// ----------------------------------------------------------------------------
package tllru_pkg;

  localparam int ACTIVE_DEPTH_DEF = 16;
  localparam int SECOND_DEPTH_DEF = 16;
  localparam int PAGE_BITS_DEF    = 20;

  localparam int SIZE_W      = 5;
  localparam int SIZE_RESET  = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  typedef enum logic [1:0] {
    ACT_FREE       = 2'd0,
    ACT_PROMOTE    = 2'd1,
    ACT_NEW_DEMOTE = 2'd2,
    ACT_NEW_EVICT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,
    CELL_RIGHT = 2'd2
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_COMMIT = 2'd2
  } state_t;

  typedef enum logic {
    REG_ACTIVE_SIZE = 1'b0,
    REG_SECOND_SIZE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] active_size;
    logic [SIZE_W-1:0] second_size;
  } cfg_t;

endpackage

// ===== hdl/tllru_in_if.sv =====
// ----------------------------------------------------------------------------
// tllru_in_if
// fault channel: one faulting page number per item
// ----------------------------------------------------------------------------
interface tllru_in_if #(
  parameter int PAGE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] fault_page;

  modport source (output valid, output fault_page, input ready);
  modport sink   (input valid, input fault_page, output ready);
endinterface

// ===== hdl/tllru_out_if.sv =====
// ----------------------------------------------------------------------------
// tllru_out_if
// result channel: action taken plus demoted and evicted pages
// ----------------------------------------------------------------------------
interface tllru_out_if #(
  parameter int PAGE_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [PAGE_BITS-1:0] demoted_page;
  logic                 demoted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic                 evicted_valid;

  modport source (output valid, output action, output demoted_page, output demoted_valid,
                  output evicted_page, output evicted_valid, input ready);
  modport sink   (input valid, input action, input demoted_page, input demoted_valid,
                  input evicted_page, input evicted_valid, output ready);
endinterface

// ===== hdl/two_list_lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// two_list_lru_page_replacement
// active list plus second-chance list, one row of shifting cells per list
// ----------------------------------------------------------------------------
// Each fault item passes from acceptance to a loaded result register through a search
// cycle, in which every second-list cell compares its page with the fault in parallel
// and both rows select their tail entry by fill count, then a commit cycle, which picks
// the match nearest the head and shifts the active row and, as the action needs, the
// second row by one shift step. The next item is accepted in the commit cycle while
// results are taken; a stalled result holds the commit cycle. Both rows are sized by
// ACTIVE_DEPTH and SECOND_DEPTH. The user sets list sizes through the cfg_ port while
// the block is idle, which is not enforced. No clearing pass is needed after reset.
module two_list_lru_page_replacement
  import tllru_pkg::*;
#(
  parameter int ACTIVE_DEPTH = ACTIVE_DEPTH_DEF,
  parameter int SECOND_DEPTH = SECOND_DEPTH_DEF,
  parameter int PAGE_BITS    = PAGE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tllru_in_if.sink              in_ch,
  tllru_out_if.source           out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int ACW  = $clog2(ACTIVE_DEPTH + 1);
  localparam int SCW  = $clog2(SECOND_DEPTH + 1);
  localparam int MW   = (ACW > SCW) ? ACW : SCW;
  localparam int CMPW = ((MW > SIZE_W) ? MW : SIZE_W) + 1;

  cfg_t cfg;

  tllru_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // control
  state_t state_r;
  state_t state_nxt;
  logic   commit_en;
  logic   accept;

  logic [PAGE_BITS-1:0]    page_r;
  logic [ACW-1:0]          acnt_r;
  logic [ACW-1:0]          acnt_nxt;
  logic [SCW-1:0]          scnt_r;
  logic [SCW-1:0]          scnt_nxt;
  logic [SECOND_DEPTH-1:0] match_r;
  logic [PAGE_BITS-1:0]    dem_r;
  logic [PAGE_BITS-1:0]    ev_r;

  // rows
  cell_op_t             a_op [ACTIVE_DEPTH];
  cell_op_t             s_op [SECOND_DEPTH];
  logic [PAGE_BITS-1:0] a_data [ACTIVE_DEPTH];
  logic [PAGE_BITS-1:0] s_data [SECOND_DEPTH];
  logic [PAGE_BITS-1:0] a_tail;
  logic [PAGE_BITS-1:0] s_tail;
  logic [SECOND_DEPTH-1:0] match;

  tllru_row #(.DEPTH(ACTIVE_DEPTH), .PAGE_BITS(PAGE_BITS)) u_active (
    .clk       (clk),
    .head_data (page_r),
    .op        (a_op),
    .count     (acnt_r),
    .data      (a_data),
    .tail_data (a_tail)
  );

  tllru_row #(.DEPTH(SECOND_DEPTH), .PAGE_BITS(PAGE_BITS)) u_second (
    .clk       (clk),
    .head_data (dem_r),
    .op        (s_op),
    .count     (scnt_r),
    .data      (s_data),
    .tail_data (s_tail)
  );

  always_comb begin
    for (int i = 0; i < SECOND_DEPTH; i++) begin
      match[i] = (SCW'(i) < scnt_r) && (s_data[i] == page_r);
    end
  end

  // decisions of the commit cycle
  logic [CMPW-1:0] ea;
  logic [CMPW-1:0] es;
  logic [CMPW-1:0] total;
  logic [CMPW-1:0] limit;
  logic            below_limit;
  logic            room;
  logic            found;
  logic            dv;
  logic            ev;
  action_t         action;
  logic [SECOND_DEPTH-1:0] hit_oh;
  logic [SECOND_DEPTH-1:0] hit_below;
  logic [SECOND_DEPTH-1:0] le_mask;
  logic [SCW-1:0]  scnt_after;

  always_comb begin
    ea = CMPW'(cfg.active_size);
    if (ea == '0) ea = CMPW'(1);
    else if (ea > CMPW'(ACTIVE_DEPTH)) ea = CMPW'(ACTIVE_DEPTH);
    es = CMPW'(cfg.second_size);
    if (es == '0) es = CMPW'(1);
    else if (es > CMPW'(SECOND_DEPTH)) es = CMPW'(SECOND_DEPTH);
  end

  assign total       = CMPW'(acnt_r) + CMPW'(scnt_r);
  assign limit       = ea + es;
  assign below_limit = total < limit;
  assign room        = below_limit && (CMPW'(acnt_r) < ea);
  assign found       = |match_r;
  assign hit_oh      = match_r & (~match_r + 1'b1);
  assign hit_below   = hit_oh - 1'b1;
  assign le_mask     = hit_oh | hit_below;
  assign dv          = !room && (acnt_r != '0);
  assign ev          = !room && !found && !below_limit && (scnt_r != '0);

  always_comb begin
    if (room) action = ACT_FREE;
    else if (found) action = ACT_PROMOTE;
    else if (below_limit) action = ACT_NEW_DEMOTE;
    else action = ACT_NEW_EVICT;
  end

  always_comb begin
    scnt_after = ev ? scnt_r - 1'b1 : scnt_r;
    acnt_nxt   = acnt_r;
    scnt_nxt   = scnt_r;
    for (int i = 0; i < ACTIVE_DEPTH; i++) a_op[i] = CELL_HOLD;
    for (int i = 0; i < SECOND_DEPTH; i++) s_op[i] = CELL_HOLD;
    if (commit_en) begin
      // the fault page always lands at the active head
      for (int i = 0; i < ACTIVE_DEPTH; i++) a_op[i] = CELL_LEFT;
      if (room) begin
        acnt_nxt = (acnt_r == ACW'(ACTIVE_DEPTH)) ? acnt_r : acnt_r + 1'b1;
      end else begin
        acnt_nxt = dv ? acnt_r : ACW'(1);
        if (found) begin
          if (dv) begin
            // close the gap and push the demoted page in one step
            for (int i = 0; i < SECOND_DEPTH; i++) begin
              if (le_mask[i]) s_op[i] = CELL_LEFT;
            end
          end else begin
            for (int i = 0; i < SECOND_DEPTH; i++) begin
              if (!hit_below[i]) s_op[i] = CELL_RIGHT;
            end
            scnt_nxt = scnt_r - 1'b1;
          end
        end else if (dv) begin
          for (int i = 0; i < SECOND_DEPTH; i++) s_op[i] = CELL_LEFT;
          scnt_nxt = (scnt_after == SCW'(SECOND_DEPTH)) ? scnt_after : scnt_after + 1'b1;
        end else begin
          scnt_nxt = scnt_after;
        end
      end
    end
  end

  // state machine
  always_comb begin
    case (state_r)
      ST_IDLE:   state_nxt = in_ch.valid ? ST_SEARCH : ST_IDLE;
      ST_SEARCH: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (commit_en) state_nxt = in_ch.valid ? ST_SEARCH : ST_IDLE;
        else state_nxt = ST_COMMIT;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  logic out_valid_r;

  always_comb begin
    commit_en   = (state_r == ST_COMMIT) && (!out_valid_r || out_ch.ready);
    in_ch.ready = (state_r == ST_IDLE) || commit_en;
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acnt_r      <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acnt_r  <= acnt_nxt;
      scnt_r  <= scnt_nxt;
      if (commit_en) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  action_t              action_r;
  logic [PAGE_BITS-1:0] dem_out_r;
  logic                 dv_r;
  logic [PAGE_BITS-1:0] ev_out_r;
  logic                 ev_valid_r;

  always_ff @(posedge clk) begin
    if (accept) page_r <= in_ch.fault_page;
    if (state_r == ST_SEARCH) begin
      match_r <= match;
      dem_r   <= a_tail;
      ev_r    <= s_tail;
    end
    if (commit_en) begin
      action_r   <= action;
      dem_out_r  <= dv ? dem_r : '0;
      dv_r       <= dv;
      ev_out_r   <= ev ? ev_r : '0;
      ev_valid_r <= ev;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.action        = action_r;
  assign out_ch.demoted_page  = dem_out_r;
  assign out_ch.demoted_valid = dv_r;
  assign out_ch.evicted_page  = ev_out_r;
  assign out_ch.evicted_valid = ev_valid_r;

endmodule

// ===== hdl/tllru_cell.sv =====
// ----------------------------------------------------------------------------
// tllru_cell
// one list entry: holds, takes its left neighbor or takes its right neighbor
// ----------------------------------------------------------------------------
module tllru_cell
  import tllru_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  cell_op_t             op,
  input  logic [PAGE_BITS-1:0] left_in,
  input  logic [PAGE_BITS-1:0] right_in,
  output logic [PAGE_BITS-1:0] data
);

  logic [PAGE_BITS-1:0] data_r;
  logic [PAGE_BITS-1:0] data_nxt;

  always_comb begin
    case (op)
      CELL_LEFT:  data_nxt = left_in;
      CELL_RIGHT: data_nxt = right_in;
      CELL_HOLD:  data_nxt = data_r;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== hdl/tllru_row.sv =====
// ----------------------------------------------------------------------------
// tllru_row
// row of list cells, head at cell 0, with tail select by fill count
// ----------------------------------------------------------------------------
module tllru_row
  import tllru_pkg::*;
#(
  parameter int DEPTH     = ACTIVE_DEPTH_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  localparam int CW       = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic [PAGE_BITS-1:0] head_data,
  input  cell_op_t             op [DEPTH],
  input  logic [CW-1:0]        count,
  output logic [PAGE_BITS-1:0] data [DEPTH],
  output logic [PAGE_BITS-1:0] tail_data
);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PAGE_BITS-1:0] left_in;
    logic [PAGE_BITS-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in = head_data;
    end else begin : g_mid
      assign left_in = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = data[i];
    end else begin : g_inner
      assign right_in = data[i+1];
    end

    tllru_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
      .clk      (clk),
      .op       (op[i]),
      .left_in  (left_in),
      .right_in (right_in),
      .data     (data[i])
    );
  end

  // tail is the cell at count - 1, zero when the row is empty
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count == CW'(i + 1)) tail_data = tail_data | data[i];
    end
  end

endmodule

// ===== hdl/tllru_cfg.sv =====
// ----------------------------------------------------------------------------
// tllru_cfg
// apb register port for the two list sizes
// ----------------------------------------------------------------------------
module tllru_cfg
  import tllru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [SIZE_W-1:0] active_size_r;
  logic [SIZE_W-1:0] active_size_nxt;
  logic [SIZE_W-1:0] second_size_r;
  logic [SIZE_W-1:0] second_size_nxt;
  reg_idx_t          idx;
  logic              wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    active_size_nxt = active_size_r;
    second_size_nxt = second_size_r;
    if (wr_en) begin
      case (idx)
        REG_ACTIVE_SIZE: active_size_nxt = pwdata[SIZE_W-1:0];
        REG_SECOND_SIZE: second_size_nxt = pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= SIZE_W'(SIZE_RESET);
      second_size_r <= SIZE_W'(SIZE_RESET);
    end else begin
      active_size_r <= active_size_nxt;
      second_size_r <= second_size_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_ACTIVE_SIZE: prdata = CFG_DATA_W'(active_size_r);
      REG_SECOND_SIZE: prdata = CFG_DATA_W'(second_size_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.active_size = active_size_r;
  assign cfg.second_size = second_size_r;

endmodule

// ===== hdl/tllru_checker.sv =====
// ----------------------------------------------------------------------------
// tllru_checker
// port-level checks of the page replacement block, bound to the top level
// ----------------------------------------------------------------------------
`include "two_list_lru_page_replacement_assert.svh"

module tllru_checker
  import tllru_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           action,
  input logic [PAGE_BITS-1:0] demoted_page,
  input logic                 demoted_valid,
  input logic [PAGE_BITS-1:0] evicted_page,
  input logic                 evicted_valid
);

  // a stalled result holds
  `TLLRU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(action) && $stable(demoted_page) && $stable(evicted_page) && $stable(demoted_valid) && $stable(evicted_valid))

  // the search cycle never takes an item
  `TLLRU_ASSERT_NEXT(a_search_busy, clk, rst_n, in_valid && in_ready, !in_ready)

  // a free slot placement moves nothing between lists
  `TLLRU_ASSERT_NOW(a_free_quiet, clk, rst_n, out_valid && action == ACT_FREE, !demoted_valid && !evicted_valid)

  // eviction only with the full-lists action
  `TLLRU_ASSERT_NOW(a_evict_action, clk, rst_n, out_valid && evicted_valid, action == ACT_NEW_EVICT)

  // pages without their valid bit read as zero
  `TLLRU_ASSERT_NOW(a_zero_pages, clk, rst_n, out_valid, (demoted_valid || demoted_page == '0) && (evicted_valid || evicted_page == '0))

endmodule

bind two_list_lru_page_replacement tllru_checker #(.PAGE_BITS(PAGE_BITS)) u_tllru_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .action        (out_ch.action),
  .demoted_page  (out_ch.demoted_page),
  .demoted_valid (out_ch.demoted_valid),
  .evicted_page  (out_ch.evicted_page),
  .evicted_valid (out_ch.evicted_valid)
);
